// ----- hw/rtl/usp_pkg.sv -----
package usp_pkg;

    // Character constants
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Largest port number that fits the port field
    localparam logic [15:0] PORT_MAX = 16'hFFFF;

    // Parse phases
    localparam logic [2:0] PH_SCHEME = 3'd0;
    localparam logic [2:0] PH_SEP    = 3'd1;
    localparam logic [2:0] PH_HOST   = 3'd2;
    localparam logic [2:0] PH_PORT   = 3'd3;
    localparam logic [2:0] PH_PATH   = 3'd4;

    // Field tags
    localparam logic [2:0] TAG_SCHEME = 3'd0;
    localparam logic [2:0] TAG_SEP    = 3'd1;
    localparam logic [2:0] TAG_HOST   = 3'd2;
    localparam logic [2:0] TAG_PORT   = 3'd3;
    localparam logic [2:0] TAG_PATH   = 3'd4;
    localparam logic [2:0] TAG_IGN    = 3'd5;

    // Status codes
    localparam logic [2:0] ST_RUN     = 3'd0;
    localparam logic [2:0] ST_DONE    = 3'd1;
    localparam logic [2:0] ST_BADSEP  = 3'd2;
    localparam logic [2:0] ST_OVF     = 3'd3;
    localparam logic [2:0] ST_BADPORT = 3'd4;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } in_t;

    typedef struct packed {
        logic [2:0]  field_tag;
        logic [2:0]  status;
        logic [15:0] port_value;
        logic        port_seen;
        logic        url_end;
    } out_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [15:0] port_acc;
        logic        slash_one;
        logic        port_flag;
        logic        halted;
    } parse_state_t;

    localparam parse_state_t PARSE_RESET = '{
        phase:     PH_SCHEME,
        port_acc:  16'd0,
        slash_one: 1'b0,
        port_flag: 1'b0,
        halted:    1'b0
    };

endpackage

// ----- hw/rtl/usp_step.sv -----
module usp_step (
    input  usp_pkg::parse_state_t cur,
    input  usp_pkg::in_t          item,
    output usp_pkg::parse_state_t nxt,
    output usp_pkg::out_t         result
);

    logic        is_digit;
    logic [3:0]  digit_val;
    logic [19:0] port_cand;
    logic [2:0]  tag;
    logic [2:0]  status;
    logic        url_end;
    usp_pkg::parse_state_t upd;

    // Decode the port digit and form acc * 10 + digit
    assign is_digit  = (item.ch >= usp_pkg::CH_ZERO) && (item.ch <= usp_pkg::CH_NINE);
    assign digit_val = item.ch[3:0];
    assign port_cand = ({4'd0, cur.port_acc} << 3) + ({4'd0, cur.port_acc} << 1)
                     + {16'd0, digit_val};

    // Advance the parse by one character
    always_comb
    begin
        upd     = cur;
        tag     = usp_pkg::TAG_IGN;
        status  = usp_pkg::ST_RUN;
        url_end = 1'b0;
        if (!cur.halted)
        begin
            if ((item.ch == usp_pkg::CH_NUL) && (cur.phase != usp_pkg::PH_SEP))
            begin
                status = usp_pkg::ST_DONE;
            end
            else
            begin
                unique case (cur.phase)
                    usp_pkg::PH_SCHEME:
                    begin
                        if (item.ch == usp_pkg::CH_COLON)
                        begin
                            tag           = usp_pkg::TAG_SEP;
                            upd.phase     = usp_pkg::PH_SEP;
                            upd.slash_one = 1'b0;
                        end
                        else
                        begin
                            tag = usp_pkg::TAG_SCHEME;
                        end
                    end
                    usp_pkg::PH_SEP:
                    begin
                        if (item.ch == usp_pkg::CH_SLASH)
                        begin
                            tag           = usp_pkg::TAG_SEP;
                            upd.slash_one = 1'b1;
                            if (cur.slash_one)
                            begin
                                upd.phase = usp_pkg::PH_HOST;
                            end
                        end
                        else
                        begin
                            status = usp_pkg::ST_BADSEP;
                        end
                    end
                    usp_pkg::PH_HOST:
                    begin
                        if (item.ch == usp_pkg::CH_COLON)
                        begin
                            tag           = usp_pkg::TAG_SEP;
                            upd.phase     = usp_pkg::PH_PORT;
                            upd.port_flag = 1'b1;
                            upd.port_acc  = 16'd0;
                        end
                        else if (item.ch == usp_pkg::CH_SLASH)
                        begin
                            tag       = usp_pkg::TAG_PATH;
                            upd.phase = usp_pkg::PH_PATH;
                        end
                        else
                        begin
                            tag = usp_pkg::TAG_HOST;
                        end
                    end
                    usp_pkg::PH_PORT:
                    begin
                        if (is_digit)
                        begin
                            if (port_cand > {4'd0, usp_pkg::PORT_MAX})
                            begin
                                status = usp_pkg::ST_OVF;
                            end
                            else
                            begin
                                upd.port_acc = port_cand[15:0];
                                tag          = usp_pkg::TAG_PORT;
                            end
                        end
                        else if (item.ch == usp_pkg::CH_SLASH)
                        begin
                            tag       = usp_pkg::TAG_PATH;
                            upd.phase = usp_pkg::PH_PATH;
                        end
                        else
                        begin
                            status = usp_pkg::ST_BADPORT;
                        end
                    end
                    default:
                    begin
                        tag       = usp_pkg::TAG_PATH;
                        upd.phase = usp_pkg::PH_PATH;
                    end
                endcase
            end
            // End the URL on an error or NUL, and halt; the last character also ends it
            if (status != usp_pkg::ST_RUN)
            begin
                url_end    = 1'b1;
                upd.halted = 1'b1;
            end
            else if (item.last)
            begin
                status  = usp_pkg::ST_DONE;
                url_end = 1'b1;
            end
        end
    end

    // Report the updated port, then drop all state on the last character
    assign result.field_tag  = tag;
    assign result.status     = status;
    assign result.port_value = upd.port_acc;
    assign result.port_seen  = upd.port_flag;
    assign result.url_end    = url_end;
    assign nxt = item.last ? usp_pkg::PARSE_RESET : upd;

endmodule

// ----- hw/rtl/url_splitter_stream.sv -----
// Each character passes through the input register, then the result register.
// Throughput: one character per cycle unless the output stalls; the parse step is a single
// combinational pass between the input and result registers, with the parse state updated alongside.
// Reset (rst_n, asynchronous, active low) empties both registers and returns the parser
// to the scheme phase with no port seen.
module url_splitter_stream (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  usp_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output usp_pkg::out_t out_data
);

    usp_pkg::in_t          in_data_reg;
    logic                  in_valid_reg;
    logic                  in_valid_next;
    usp_pkg::parse_state_t state_reg;
    usp_pkg::parse_state_t state_next;
    usp_pkg::out_t         out_data_reg;
    usp_pkg::out_t         step_result;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  stage_free;
    logic                  advance;
    logic                  in_take;

    // Handshake: the result register frees when empty or being taken
    assign stage_free = !out_valid_reg || out_ready;
    assign advance    = in_valid_reg && stage_free;
    assign in_ready   = !in_valid_reg || stage_free;
    assign in_take    = in_valid && in_ready;

    usp_step u_step (
        .cur    (state_reg),
        .item   (in_data_reg),
        .nxt    (state_next),
        .result (step_result)
    );

    // Track occupancy of both registers
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= usp_pkg::PARSE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers: hold until the stage moves
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- hw/rtl/usp_checker.sv -----
module usp_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input usp_pkg::in_t  in_data,
    input logic          out_valid,
    input logic          out_ready,
    input usp_pkg::out_t out_data
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

    // Any final status comes with the end mark, and the end mark with a final status
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.status != usp_pkg::ST_RUN) == out_data.url_end))
    else $error("status and url_end disagree");

    // Port digits only once a port has started
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.field_tag == usp_pkg::TAG_PORT) |-> out_data.port_seen)
    else $error("port digit without port");

    // Errors tag the offending character as ignored
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((out_data.status == usp_pkg::ST_BADSEP)
                   || (out_data.status == usp_pkg::ST_OVF)
                   || (out_data.status == usp_pkg::ST_BADPORT))
        |-> (out_data.field_tag == usp_pkg::TAG_IGN))
    else $error("error result not tagged ignored");

    // The input stalls only behind a pending result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

endmodule

bind url_splitter_stream usp_checker u_usp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
